// ===== design/hvtd_pkg.sv =====
// Shared types and constants for the Hessian value token decoder.
package hvtd_pkg;

  typedef enum logic [4:0] {
    PH_IDLE  = 5'd0,
    PH_INT1  = 5'd1,
    PH_INT2  = 5'd2,
    PH_INT3  = 5'd3,
    PH_INT4  = 5'd4,
    PH_LONG1 = 5'd5,
    PH_LONG2 = 5'd6,
    PH_LONG3 = 5'd7,
    PH_LONG4 = 5'd8,
    PH_LONG5 = 5'd9,
    PH_LONG6 = 5'd10,
    PH_LONG7 = 5'd11,
    PH_LONG8 = 5'd12,
    PH_SLEN1 = 5'd13,
    PH_SLEN2 = 5'd14,
    PH_SDATA = 5'd15,
    PH_SNEXT = 5'd16
  } phase_t;

  typedef enum logic [2:0] {
    K_NULL   = 3'd0,
    K_BOOL   = 3'd1,
    K_INT    = 3'd2,
    K_LONG   = 3'd3,
    K_DATE   = 3'd4,
    K_SBYTE  = 3'd5,
    K_SEMPTY = 3'd6,
    K_ERR    = 3'd7
  } kind_t;

  typedef enum logic [2:0] {
    AK_NONE   = 3'd0,
    AK_INT    = 3'd2,
    AK_LONG   = 3'd3,
    AK_DATE   = 3'd4,
    AK_LONG32 = 3'd5,
    AK_MINUTE = 3'd6
  } accum_kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [63:0] value;
    logic        last;
    logic        minute;
  } q_entry_t;

  localparam logic signed [16:0] MinuteMs = 17'sd60000;

  localparam int IntOffset      = 'h90;
  localparam int Int2Offset     = 'hc8;
  localparam int Int3Offset     = 'hd4;
  localparam int LongOffset     = 'he0;
  localparam int Long2Offset    = 'hf8;
  localparam int Long3Offset    = 'h3c;
  localparam logic [7:0] StrMidBase = 8'h30;
  localparam logic [7:0] TagLong32  = 8'h59;
  localparam logic [7:0] TagDateMs  = 8'h4a;
  localparam logic [7:0] TagDateMin = 8'h4b;
  localparam logic [7:0] TagNull    = 8'h4e;
  localparam logic [7:0] TagTrue    = 8'h54;
  localparam logic [7:0] TagFalse   = 8'h46;
  localparam logic [7:0] TagInt     = 8'h49;
  localparam logic [7:0] TagLong    = 8'h4c;
  localparam logic [7:0] TagChunk   = 8'h52;
  localparam logic [7:0] TagString  = 8'h53;

endpackage

// ===== design/hvtd_front.sv =====
// Front end: byte parser that classifies tags, gathers numbers and queues results.
module hvtd_front import hvtd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] in_byte,
  input  logic       clear_state,
  output logic       res_valid,
  output q_entry_t   res
);

  typedef struct packed {
    phase_t      phase;
    logic [63:0] accum;
    logic [15:0] bytes_left;
    logic        in_chunk;
    accum_kind_t akind;
    logic        emit;
    kind_t       kind;
    logic [63:0] value;
    logic        last;
  } tag_dec_t;

  function automatic logic [63:0] sext32(input logic [63:0] v);
    return {{32{v[31]}}, v[31:0]};
  endfunction

  function automatic logic is_string_tag(input logic [7:0] c);
    return (c <= 8'h1f) || (c >= 8'h30 && c <= 8'h33) || c == TagChunk || c == TagString;
  endfunction

  function automatic tag_dec_t decode_tag(input logic [7:0] c);
    tag_dec_t d;
    d.phase      = PH_IDLE;
    d.accum      = '0;
    d.bytes_left = '0;
    d.in_chunk   = 1'b0;
    d.akind      = AK_NONE;
    d.emit       = 1'b0;
    d.kind       = K_NULL;
    d.value      = '0;
    d.last       = 1'b0;
    priority if (c <= 8'h1f) begin
      d.bytes_left = {8'h00, c};
      if (c != 8'h00) begin
        d.phase = PH_SDATA;
      end else begin
        d.emit = 1'b1;
        d.kind = K_SEMPTY;
        d.last = 1'b1;
      end
    end else if (c >= 8'h30 && c <= 8'h33) begin
      d.bytes_left = {c - StrMidBase, 8'h00};
      d.phase      = PH_SLEN2;
    end else if (c == TagChunk || c == TagString) begin
      d.in_chunk = (c == TagChunk);
      d.phase    = PH_SLEN1;
    end else if (c == TagNull) begin
      d.emit = 1'b1;
      d.kind = K_NULL;
    end else if (c == TagTrue || c == TagFalse) begin
      d.emit  = 1'b1;
      d.kind  = K_BOOL;
      d.value = {63'd0, c == TagTrue};
    end else if (c >= 8'h80 && c <= 8'hbf) begin
      d.emit  = 1'b1;
      d.kind  = K_INT;
      d.value = 64'(int'(c) - IntOffset);
    end else if (c >= 8'hc0 && c <= 8'hcf) begin
      d.accum = 64'((int'(c) - Int2Offset) * 256);
      d.akind = AK_INT;
      d.phase = PH_INT4;
    end else if (c >= 8'hd0 && c <= 8'hd7) begin
      d.accum = 64'((int'(c) - Int3Offset) * 65536);
      d.akind = AK_INT;
      d.phase = PH_INT3;
    end else if (c == TagInt) begin
      d.akind = AK_INT;
      d.phase = PH_INT1;
    end else if (c >= 8'hd8 && c <= 8'hef) begin
      d.emit  = 1'b1;
      d.kind  = K_LONG;
      d.value = 64'(int'(c) - LongOffset);
    end else if (c >= 8'hf0) begin
      d.accum = 64'((int'(c) - Long2Offset) * 256);
      d.akind = AK_LONG;
      d.phase = PH_LONG8;
    end else if (c >= 8'h38 && c <= 8'h3f) begin
      d.accum = 64'((int'(c) - Long3Offset) * 65536);
      d.akind = AK_LONG;
      d.phase = PH_LONG7;
    end else if (c == TagLong32) begin
      d.akind = AK_LONG32;
      d.phase = PH_LONG5;
    end else if (c == TagLong) begin
      d.akind = AK_LONG;
      d.phase = PH_LONG1;
    end else if (c == TagDateMs) begin
      d.akind = AK_DATE;
      d.phase = PH_LONG1;
    end else if (c == TagDateMin) begin
      d.akind = AK_MINUTE;
      d.phase = PH_LONG5;
    end else if ((c >= 8'h55 && c <= 8'h58) || (c >= 8'h70 && c <= 8'h7f)) begin
      d.emit = 1'b0;
    end else begin
      d.emit = 1'b1;
      d.kind = K_ERR;
    end
    return d;
  endfunction

  phase_t      phase, phase_next, cur_phase;
  logic [63:0] accum, accum_next, acc_ins;
  logic [15:0] bytes_left, bytes_left_next, cur_left, left_sum, left_dec;
  logic        in_chunk, in_chunk_next, cur_chunk;
  accum_kind_t akind, akind_next;
  logic [2:0]  int_idx, long_idx;
  tag_dec_t    td;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      bytes_left <= '0;
      in_chunk   <= 1'b0;
      akind      <= AK_NONE;
    end else begin
      phase      <= phase_next;
      bytes_left <= bytes_left_next;
      in_chunk   <= in_chunk_next;
      akind      <= akind_next;
    end
  end

  always_ff @(posedge clk) begin
    accum <= accum_next;
  end

  always_comb begin
    cur_phase = clear_state ? PH_IDLE : phase;
    cur_left  = clear_state ? 16'd0 : bytes_left;
    cur_chunk = clear_state ? 1'b0 : in_chunk;
    td        = decode_tag(in_byte);
    int_idx   = 3'(PH_INT4 - cur_phase);
    long_idx  = 3'(PH_LONG8 - cur_phase);
    left_sum  = cur_left | {8'h00, in_byte};
    left_dec  = cur_left - 16'd1;
    acc_ins   = accum;

    phase_next      = phase;
    accum_next      = accum;
    bytes_left_next = bytes_left;
    in_chunk_next   = in_chunk;
    akind_next      = akind;
    res_valid       = 1'b0;
    res.kind        = K_NULL;
    res.value       = '0;
    res.last        = 1'b0;
    res.minute      = 1'b0;

    if (accept) begin
      unique case (cur_phase)
        PH_INT1, PH_INT2, PH_INT3, PH_INT4: begin
          acc_ins[{int_idx, 3'b000} +: 8] = in_byte;
          accum_next = acc_ins;
          if (cur_phase == PH_INT4) begin
            res_valid = 1'b1;
            res.kind  = K_INT;
            res.value = sext32(acc_ins);
            phase_next = PH_IDLE;
          end else begin
            phase_next = phase_t'(cur_phase + 5'd1);
          end
        end
        PH_LONG1, PH_LONG2, PH_LONG3, PH_LONG4,
        PH_LONG5, PH_LONG6, PH_LONG7, PH_LONG8: begin
          acc_ins[{long_idx, 3'b000} +: 8] = in_byte;
          accum_next = acc_ins;
          if (cur_phase == PH_LONG8) begin
            res_valid  = 1'b1;
            phase_next = PH_IDLE;
            res.value  = acc_ins;
            unique case (akind)
              AK_LONG32: begin
                res.kind  = K_LONG;
                res.value = sext32(acc_ins);
              end
              AK_MINUTE: begin
                res.kind   = K_DATE;
                res.minute = 1'b1;
              end
              AK_DATE:   res.kind = K_DATE;
              default:   res.kind = K_LONG;
            endcase
          end else begin
            phase_next = phase_t'(cur_phase + 5'd1);
          end
        end
        PH_SLEN1: begin
          bytes_left_next = {in_byte, 8'h00};
          in_chunk_next   = cur_chunk;
          phase_next      = PH_SLEN2;
        end
        PH_SLEN2: begin
          bytes_left_next = left_sum;
          in_chunk_next   = cur_chunk;
          if (left_sum != 16'd0) begin
            phase_next = PH_SDATA;
          end else if (cur_chunk) begin
            phase_next = PH_SNEXT;
          end else begin
            phase_next    = PH_IDLE;
            in_chunk_next = 1'b0;
            res_valid     = 1'b1;
            res.kind      = K_SEMPTY;
            res.last      = 1'b1;
          end
        end
        PH_SDATA: begin
          bytes_left_next = left_dec;
          in_chunk_next   = cur_chunk;
          res_valid       = 1'b1;
          res.kind        = K_SBYTE;
          res.value       = {56'd0, in_byte};
          if (left_dec == 16'd0) begin
            if (cur_chunk) begin
              phase_next = PH_SNEXT;
            end else begin
              phase_next    = PH_IDLE;
              in_chunk_next = 1'b0;
              res.last      = 1'b1;
            end
          end
        end
        PH_SNEXT, PH_IDLE: begin
          if (cur_phase == PH_SNEXT && !is_string_tag(in_byte)) begin
            phase_next      = PH_IDLE;
            bytes_left_next = '0;
            in_chunk_next   = 1'b0;
            akind_next      = AK_NONE;
            res_valid       = 1'b1;
            res.kind        = K_ERR;
          end else begin
            phase_next      = td.phase;
            accum_next      = td.accum;
            bytes_left_next = td.bytes_left;
            in_chunk_next   = td.in_chunk;
            akind_next      = td.akind;
            res_valid       = td.emit;
            res.kind        = td.kind;
            res.value       = td.value;
            res.last        = td.last;
          end
        end
        default: begin
          phase_next      = PH_IDLE;
          bytes_left_next = '0;
          in_chunk_next   = 1'b0;
          akind_next      = AK_NONE;
        end
      endcase
    end
  end

endmodule

// ===== design/hvtd_fifo.sv =====
// Short result queue between the parser and the output stage.
module hvtd_fifo import hvtd_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     wr_en,
  input  q_entry_t wr_data,
  input  logic     rd_en,
  output logic     rd_valid,
  output q_entry_t rd_data,
  output logic     full
);

  localparam int PtrW = $clog2(DEPTH);
  localparam int CntW = $clog2(DEPTH + 1);

  q_entry_t            mem [DEPTH];
  logic [PtrW-1:0]     wr_ptr, rd_ptr;
  logic [CntW-1:0]     count;
  logic                do_wr, do_rd;

  assign rd_valid = (count != '0);
  assign full     = (count == CntW'(DEPTH));
  assign rd_data  = mem[rd_ptr];
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && rd_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + PtrW'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + PtrW'(1);
      end
      count <= count + CntW'(do_wr) - CntW'(do_rd);
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

endmodule

// ===== design/hvtd_back.sv =====
// Back end: minute scaling and the output register facing the result queue.
module hvtd_back import hvtd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  q_entry_t           q_data,
  output logic               q_take,
  output logic               out_valid,
  input  logic               out_pop,
  output logic [2:0]         kind,
  output logic signed [63:0] value,
  output logic               string_last
);

  logic signed [48:0] prod;
  logic [63:0]        scaled;

  assign q_take = q_valid && (!out_valid || out_pop);

  always_comb begin
    prod   = $signed(q_data.value[31:0]) * MinuteMs;
    scaled = q_data.minute ? {{15{prod[48]}}, prod} : q_data.value;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_take) begin
      out_valid <= 1'b1;
    end else if (out_pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_take) begin
      kind        <= q_data.kind;
      value       <= $signed(scaled);
      string_last <= q_data.last;
    end
  end

endmodule

// ===== design/hessian_value_token_decoder_top.sv =====
// Top level of the Hessian 2.0 value token decoder.
// Input side is a queue write port: in_byte and clear_state are taken at an
// edge with push high and full low. clear_state returns the parser to idle
// before that byte is parsed.
// Result side is a queue read port: while empty is low, kind, value and
// string_last hold the oldest result; it is taken at an edge with pop high.
// The parser takes one byte a cycle while full is low and pushes at most one
// result into a QUEUE_DEPTH entry queue; the output stage scales minute dates
// by 60000 and registers the result. A result passes through the queue and
// then the output register before it is on the output ports and can be
// popped; the block sustains one byte per cycle while pop is kept high.
// Bytes that complete no value yield no result.
// When pop stays low the output register holds, the queue fills and full
// rises, so no byte is taken until a result leaves.
// Reset (synchronous rst) empties the queue and output register and puts the
// parser in idle, waiting for a tag.
module hessian_value_token_decoder_top import hvtd_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [7:0]         in_byte,
  input  logic               clear_state,
  output logic               empty,
  input  logic               pop,
  output logic [2:0]         kind,
  output logic signed [63:0] value,
  output logic               string_last
);

  logic     accept;
  logic     res_valid;
  q_entry_t res;
  logic     q_valid, q_take, out_valid;
  q_entry_t q_data;

  assign accept = push && !full;
  assign empty  = !out_valid;

  hvtd_front u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .in_byte     (in_byte),
    .clear_state (clear_state),
    .res_valid   (res_valid),
    .res         (res)
  );

  hvtd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (res_valid),
    .wr_data  (res),
    .rd_en    (q_take),
    .rd_valid (q_valid),
    .rd_data  (q_data),
    .full     (full)
  );

  hvtd_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_data      (q_data),
    .q_take      (q_take),
    .out_valid   (out_valid),
    .out_pop     (pop),
    .kind        (kind),
    .value       (value),
    .string_last (string_last)
  );

endmodule

// ===== verif/hessian_value_token_decoder_top_tb.sv =====
// Self-checking testbench for the Hessian value token decoder: byte stream in, tokens checked.
module hessian_value_token_decoder_top_tb import hvtd_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int StallLimit   = 4000;
  localparam int PhaseBeats   = 300;

  typedef struct packed {
    logic [7:0] data;
    logic       clear;
  } stream_beat_t;

  typedef struct packed {
    kind_t       kind;
    logic [63:0] value;
    logic        last;
  } token_result_t;

  logic               clk;
  logic               rst;
  logic               push;
  logic               full;
  logic [7:0]         in_byte;
  logic               clear_state;
  logic               empty;
  logic               pop;
  logic [2:0]         kind;
  logic signed [63:0] value;
  logic               string_last;

  stream_beat_t  pending_beats[$];
  token_result_t expected_tokens[$];
  logic [7:0]    token_bytes[$];

  int send_idle_pct;
  int recv_idle_pct;
  int errors;
  int stall_cycles;
  int beats_queued;
  bit in_fire;
  bit clear_next;
  bit cut_after;

  // decoder state mirror
  phase_t      ph;
  logic [63:0] acc;
  logic [15:0] remaining;
  logic        chunked;
  accum_kind_t akind;

  hessian_value_token_decoder_top uut (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .in_byte     (in_byte),
    .clear_state (clear_state),
    .empty       (empty),
    .pop         (pop),
    .kind        (kind),
    .value       (value),
    .string_last (string_last)
  );

  function automatic token_result_t make_token(kind_t k, logic [63:0] v, logic l);
    token_result_t t;
    t.kind  = k;
    t.value = v;
    t.last  = l;
    return t;
  endfunction

  function automatic logic [63:0] sext32(input logic [63:0] v);
    return {{32{v[31]}}, v[31:0]};
  endfunction

  function automatic void decoder_idle();
    ph        = PH_IDLE;
    acc       = 64'd0;
    remaining = 16'd0;
    chunked   = 1'b0;
    akind     = AK_NONE;
  endfunction

  function automatic void start_number(logic [63:0] init, accum_kind_t k, phase_t p);
    acc   = init;
    akind = k;
    ph    = p;
  endfunction

  function automatic bit is_string_tag(logic [7:0] c);
    return c <= 8'h1f || (c >= StrMidBase && c <= StrMidBase + 8'd3) ||
           c == TagChunk || c == TagString;
  endfunction

  function automatic bit segment_ready(output token_result_t r);
    r = make_token(K_NULL, 64'd0, 1'b0);
    if (remaining != 16'd0) begin
      ph = PH_SDATA;
      return 1'b0;
    end
    if (chunked) begin
      ph = PH_SNEXT;
      return 1'b0;
    end
    decoder_idle();
    r = make_token(K_SEMPTY, 64'd0, 1'b1);
    return 1'b1;
  endfunction

  function automatic bit decode_tag(input logic [7:0] c, output token_result_t r);
    logic [63:0] cw;
    cw = {56'd0, c};
    r  = make_token(K_NULL, 64'd0, 1'b0);
    if (c <= 8'h1f) begin
      chunked   = 1'b0;
      remaining = {8'd0, c};
      return segment_ready(r);
    end
    if (c >= StrMidBase && c <= StrMidBase + 8'd3) begin
      chunked   = 1'b0;
      remaining = {6'd0, c[1:0], 8'd0};
      ph        = PH_SLEN2;
      return 1'b0;
    end
    if (c == TagChunk || c == TagString) begin
      chunked   = (c == TagChunk);
      remaining = 16'd0;
      ph        = PH_SLEN1;
      return 1'b0;
    end
    if (c == TagNull) begin
      r = make_token(K_NULL, 64'd0, 1'b0);
      return 1'b1;
    end
    if (c == TagTrue || c == TagFalse) begin
      r = make_token(K_BOOL, {63'd0, c == TagTrue}, 1'b0);
      return 1'b1;
    end
    if (c >= 8'h80 && c <= 8'hbf) begin
      r = make_token(K_INT, cw - 64'(IntOffset), 1'b0);
      return 1'b1;
    end
    if (c >= 8'hc0 && c <= 8'hcf) begin
      start_number((cw - 64'(Int2Offset)) << 8, AK_INT, PH_INT4);
      return 1'b0;
    end
    if (c >= 8'hd0 && c <= 8'hd7) begin
      start_number((cw - 64'(Int3Offset)) << 16, AK_INT, PH_INT3);
      return 1'b0;
    end
    if (c == TagInt) begin
      start_number(64'd0, AK_INT, PH_INT1);
      return 1'b0;
    end
    if (c >= 8'hd8 && c <= 8'hef) begin
      r = make_token(K_LONG, cw - 64'(LongOffset), 1'b0);
      return 1'b1;
    end
    if (c >= 8'hf0) begin
      start_number((cw - 64'(Long2Offset)) << 8, AK_LONG, PH_LONG8);
      return 1'b0;
    end
    if (c >= 8'h38 && c <= 8'h3f) begin
      start_number((cw - 64'(Long3Offset)) << 16, AK_LONG, PH_LONG7);
      return 1'b0;
    end
    if (c == TagLong32) begin
      start_number(64'd0, AK_LONG32, PH_LONG5);
      return 1'b0;
    end
    if (c == TagLong) begin
      start_number(64'd0, AK_LONG, PH_LONG1);
      return 1'b0;
    end
    if (c == TagDateMs) begin
      start_number(64'd0, AK_DATE, PH_LONG1);
      return 1'b0;
    end
    if (c == TagDateMin) begin
      start_number(64'd0, AK_MINUTE, PH_LONG5);
      return 1'b0;
    end
    if ((c >= 8'h55 && c <= 8'h58) || (c >= 8'h70 && c <= 8'h7f))
      return 1'b0;
    decoder_idle();
    r = make_token(K_ERR, 64'd0, 1'b0);
    return 1'b1;
  endfunction

  function automatic bit decode_step(input logic [7:0] c, input logic clr,
                                     output token_result_t r);
    logic [63:0] v;
    accum_kind_t k;
    r = make_token(K_NULL, 64'd0, 1'b0);
    if (clr)
      decoder_idle();
    if (ph >= PH_INT1 && ph <= PH_INT4) begin
      acc = acc + ({56'd0, c} << (8 * (int'(PH_INT4) - int'(ph))));
      if (ph == PH_INT4) begin
        r = make_token(K_INT, sext32(acc), 1'b0);
        decoder_idle();
        return 1'b1;
      end
      ph = phase_t'(ph + 1);
      return 1'b0;
    end
    if (ph >= PH_LONG1 && ph <= PH_LONG8) begin
      acc = acc + ({56'd0, c} << (8 * (int'(PH_LONG8) - int'(ph))));
      if (ph != PH_LONG8) begin
        ph = phase_t'(ph + 1);
        return 1'b0;
      end
      v = acc;
      k = akind;
      decoder_idle();
      case (k)
        AK_LONG32: r = make_token(K_LONG, sext32(v), 1'b0);
        AK_MINUTE: r = make_token(K_DATE, sext32(v) * 64'(MinuteMs), 1'b0);
        AK_DATE:   r = make_token(K_DATE, v, 1'b0);
        default:   r = make_token(K_LONG, v, 1'b0);
      endcase
      return 1'b1;
    end
    case (ph)
      PH_SLEN1: begin
        remaining = {c, 8'd0};
        ph        = PH_SLEN2;
        return 1'b0;
      end
      PH_SLEN2: begin
        remaining = remaining + {8'd0, c};
        return segment_ready(r);
      end
      PH_SDATA: begin
        remaining = remaining - 16'd1;
        if (remaining != 16'd0) begin
          r = make_token(K_SBYTE, {56'd0, c}, 1'b0);
          return 1'b1;
        end
        if (chunked) begin
          ph = PH_SNEXT;
          r  = make_token(K_SBYTE, {56'd0, c}, 1'b0);
          return 1'b1;
        end
        decoder_idle();
        r = make_token(K_SBYTE, {56'd0, c}, 1'b1);
        return 1'b1;
      end
      PH_SNEXT: begin
        if (!is_string_tag(c)) begin
          decoder_idle();
          r = make_token(K_ERR, 64'd0, 1'b0);
          return 1'b1;
        end
        return decode_tag(c, r);
      end
      default: begin
        decoder_idle();
        return decode_tag(c, r);
      end
    endcase
  endfunction

  task automatic put_byte(input logic [7:0] d);
    stream_beat_t b;
    b.data  = d;
    b.clear = clear_next;
    clear_next = 1'b0;
    pending_beats.insert(pending_beats.size(), b);
    beats_queued++;
  endtask

  task automatic append_byte(input logic [7:0] d);
    token_bytes.insert(token_bytes.size(), d);
  endtask

  function automatic logic [7:0] number_byte();
    case ($urandom_range(0, 9))
      0:       return 8'h00;
      1:       return 8'hff;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic add_number(input logic [7:0] tag, input int n);
    append_byte(tag);
    repeat (n) append_byte(number_byte());
  endtask

  task automatic add_data(input int n);
    repeat (n) append_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic add_segment(input int len);
    case ($urandom_range(0, 2))
      0: append_byte(8'(len));
      1: begin
        append_byte(StrMidBase);
        append_byte(8'(len));
      end
      default: begin
        append_byte(TagString);
        append_byte(8'h00);
        append_byte(8'(len));
      end
    endcase
    add_data(len);
  endtask

  task automatic build_token();
    int hi;
    int lo;
    token_bytes.delete();
    cut_after = 1'b0;
    case ($urandom_range(0, 19))
      0:  append_byte(TagNull);
      1:  append_byte($urandom_range(0, 1) ? TagTrue : TagFalse);
      2:  append_byte(8'($urandom_range(8'h80, 8'hbf)));
      3:  add_number(8'($urandom_range(8'hc0, 8'hcf)), 1);
      4:  add_number(8'($urandom_range(8'hd0, 8'hd7)), 2);
      5:  add_number(TagInt, 4);
      6:  append_byte(8'($urandom_range(8'hd8, 8'hef)));
      7:  add_number(8'($urandom_range(8'hf0, 8'hff)), 1);
      8:  add_number(8'($urandom_range(8'h38, 8'h3f)), 2);
      9:  add_number(TagLong32, 4);
      10: add_number(TagLong, 8);
      11: add_number(TagDateMs, 8);
      12: add_number(TagDateMin, 4);
      13: begin
        lo = $urandom_range(0, 31);
        append_byte(8'(lo));
        add_data(lo);
      end
      14: begin
        if ($urandom_range(0, 49) == 0) begin
          hi = $urandom_range(1, 3);
          lo = $urandom_range(0, 255);
          if ($urandom_range(0, 1)) begin
            append_byte(TagString);
            append_byte(8'(hi));
          end else begin
            append_byte(StrMidBase + 8'(hi));
          end
          append_byte(8'(lo));
          add_data(hi * 256 + lo);
        end else begin
          add_segment($urandom_range(0, 40));
        end
      end
      15, 16: begin
        repeat ($urandom_range(1, 3)) begin
          lo = $urandom_range(0, 6);
          append_byte(TagChunk);
          append_byte(8'h00);
          append_byte(8'(lo));
          add_data(lo);
        end
        add_segment($urandom_range(0, 6));
      end
      17: append_byte($urandom_range(0, 1) ? 8'($urandom_range(8'h55, 8'h58))
                                           : 8'($urandom_range(8'h70, 8'h7f)));
      18: append_byte($urandom_range(0, 1) ? 8'($urandom_range(8'h20, 8'h2f))
                                           : 8'($urandom_range(8'h5a, 8'h6f)));
      default: begin
        case ($urandom_range(0, 2))
          0: add_data(1);
          1: begin
            append_byte(TagChunk);
            append_byte(8'h00);
            append_byte(8'h01);
            add_data(2);
          end
          default: begin
            append_byte($urandom_range(0, 1) ? TagString : TagChunk);
            add_data($urandom_range(2, 5));
            cut_after = 1'b1;
          end
        endcase
      end
    endcase
  endtask

  task automatic queue_token();
    int keep;
    build_token();
    keep = token_bytes.size();
    if (keep > 1 && $urandom_range(0, 19) == 0) begin
      keep      = $urandom_range(1, keep - 1);
      cut_after = 1'b1;
    end
    if ($urandom_range(0, 15) == 0)
      clear_next = 1'b1;
    for (int i = 0; i < keep; i++)
      put_byte(token_bytes[i]);
    if (cut_after)
      clear_next = 1'b1;
  endtask

  task automatic queue_phase(input int n);
    int start;
    start = beats_queued;
    while (beats_queued - start < n)
      queue_token();
  endtask

  task automatic drain();
    while (pending_beats.size() != 0 || push)
      @(posedge clk);
    while (expected_tokens.size() != 0)
      @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(negedge clk) begin : drive
    stream_beat_t nxt;
    if (!rst) begin
      if (!push || in_fire) begin
        if (pending_beats.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          nxt = pending_beats.pop_front();
          push        <= 1'b1;
          in_byte     <= nxt.data;
          clear_state <= nxt.clear;
        end else begin
          push <= 1'b0;
        end
      end
      pop <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin : watch
    token_result_t want;
    bit out_fire;
    if (rst) begin
      in_fire      = 1'b0;
      stall_cycles = 0;
    end else begin
      in_fire  = push && !full;
      out_fire = pop && !empty;
      if (out_fire) begin
        if (expected_tokens.size() == 0) begin
          $error("unexpected beat: kind %0d value %h string_last %0d",
                 kind, value, string_last);
          errors++;
        end else begin
          want = expected_tokens.pop_front();
          if (kind !== want.kind) begin
            $error("kind: expected %0d, actual %0d", want.kind, kind);
            errors++;
          end
          if (value !== want.value) begin
            $error("value: expected %h, actual %h", want.value, value);
            errors++;
          end
          if (string_last !== want.last) begin
            $error("string_last: expected %0d, actual %0d", want.last, string_last);
            errors++;
          end
        end
      end
      if (in_fire) begin
        if (decode_step(in_byte, clear_state, want))
          expected_tokens.insert(expected_tokens.size(), want);
      end
      if (in_fire || out_fire) begin
        stall_cycles = 0;
      end else begin
        stall_cycles = stall_cycles + 1;
        if (stall_cycles >= StallLimit) begin
          $display("SCOREBOARD MISMATCH");
          $finish;
        end
      end
    end
  end

  initial begin
    rst           = 1'b1;
    push          = 1'b0;
    pop           = 1'b0;
    in_byte       = 8'h00;
    clear_state   = 1'b0;
    errors        = 0;
    beats_queued  = 0;
    clear_next    = 1'b0;
    send_idle_pct = 28;
    recv_idle_pct = 85;
    decoder_idle();

    put_byte(TagNull);
    put_byte(TagTrue);
    put_byte(8'h80);
    put_byte(8'hbf);
    put_byte(8'h00);
    put_byte(TagChunk);
    put_byte(8'h00);
    put_byte(8'h00);
    put_byte(8'h01);
    put_byte(8'h41);
    put_byte(TagChunk);
    put_byte(8'h00);
    put_byte(8'h01);
    put_byte(8'h78);
    put_byte(TagNull);
    put_byte(8'h41);
    put_byte(8'h55);
    put_byte(8'h7f);
    put_byte(TagDateMin);
    put_byte(8'h80);
    put_byte(8'h00);
    put_byte(8'h00);
    put_byte(8'h00);
    put_byte(8'hd8);
    put_byte(8'hef);
    queue_phase(PhaseBeats);

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    drain();

    send_idle_pct = 85;
    recv_idle_pct = 28;
    queue_phase(PhaseBeats);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_phase(PhaseBeats);
    drain();

    repeat (16) @(posedge clk);
    if (errors == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
